[src/tlrq_pkg.sv]
// Shared types, constants and codes for the three-level ready queue.
`default_nettype none

package tlrq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 16;
  localparam int IN_ID_W     = 16;
  localparam int KIND_W      = 3;
  localparam int PRIO_W      = 4;
  localparam int LVL_COUNT   = 3;
  localparam int ID_KEEP     = (ID_BITS < IN_ID_W) ? ID_BITS : IN_ID_W;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH);

  typedef logic [ID_BITS-1:0] id_t;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  localparam logic [1:0] LVL_SYS   = 2'd0;
  localparam logic [1:0] LVL_INTER = 2'd1;
  localparam logic [1:0] LVL_BACK  = 2'd2;
  localparam logic [1:0] LVL_NONE  = 2'd3;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_PUSH,
    CMD_POP,
    CMD_MARK,
    CMD_COMPACT,
    CMD_CLEAR
  } cell_cmd_t;

  typedef struct packed {
    id_t               id;
    logic [KIND_W-1:0] kind;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  // Control from the sequencer to one queue row.
  typedef struct packed {
    cell_cmd_t cmd;
    entry_t    data;
    id_t       key;
  } row_ctl_t;

  // Status from one queue row back to the sequencer.
  typedef struct packed {
    entry_t head;
    logic   head_v;
    logic   full;
    logic   hit;
  } row_stat_t;

  function automatic id_t id_of(input logic [IN_ID_W-1:0] raw);
    return id_t'(raw[ID_KEEP-1:0]);
  endfunction

endpackage

`default_nettype wire

[src/tlrq_in_if.sv]
// Request channel of the ready queue: valid/ready handshake with the request fields.
`default_nettype none

interface tlrq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] proc_id;
  logic [2:0]  proc_kind;
  logic [3:0]  prio;
  logic [1:0]  level;

  modport source (output valid, output operation, output proc_id, output proc_kind,
                  output prio, output level, input ready);
  modport sink   (input valid, input operation, input proc_id, input proc_kind,
                  input prio, input level, output ready);
endinterface

`default_nettype wire

[src/tlrq_out_if.sv]
// Result channel of the ready queue: valid/ready handshake with the result fields.
`default_nettype none

interface tlrq_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_id;
  logic [2:0]  out_kind;
  logic [3:0]  out_prio;
  logic        found;
  logic [1:0]  status;
  logic [1:0]  level_used;
  logic        sys_empty;
  logic        inter_empty;
  logic        back_empty;
  logic        any_ready;

  modport source (output valid, output out_id, output out_kind, output out_prio,
                  output found, output status, output level_used, output sys_empty,
                  output inter_empty, output back_empty, output any_ready, input ready);
  modport sink   (input valid, input out_id, input out_kind, input out_prio,
                  input found, input status, input level_used, input sys_empty,
                  input inter_empty, input back_empty, input any_ready, output ready);
endinterface

`default_nettype wire

[src/tlrq_cell.sv]
// One queue slot: holds an entry and moves it toward the head on pop or compaction.
`default_nettype none

module tlrq_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tlrq_pkg::row_ctl_t ctl,
  input  wire logic               prev_v,
  input  wire logic               hole_in,
  input  wire logic               next_v,
  input  wire tlrq_pkg::entry_t   next_e,
  output tlrq_pkg::entry_t        e,
  output logic                    v,
  output logic                    hole_out,
  output logic                    hit
);
  import tlrq_pkg::*;

  entry_t e_r, e_nxt;
  logic   v_r, v_nxt;

  assign e        = e_r;
  assign v        = v_r;
  assign hit      = v_r && (e_r.id == ctl.key);
  // A hole at or ahead of this slot means everything from here back slides forward.
  assign hole_out = hole_in || !v_r;

  always_comb begin
    e_nxt = e_r;
    v_nxt = v_r;
    case (ctl.cmd)
      CMD_PUSH: begin
        if (!v_r && prev_v) begin
          e_nxt = ctl.data;
          v_nxt = 1'b1;
        end
      end
      CMD_POP: begin
        e_nxt = next_e;
        v_nxt = next_v;
      end
      CMD_MARK: begin
        if (hit) begin
          v_nxt = 1'b0;
        end
      end
      CMD_COMPACT: begin
        if (hole_out) begin
          e_nxt = next_e;
          v_nxt = next_v;
        end
      end
      CMD_CLEAR: begin
        v_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r <= e_nxt;
  end

endmodule

`default_nettype wire

[src/tlrq_row.sv]
// One ready queue: a chain of slots with the head at slot zero.
`default_nettype none

module tlrq_row (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tlrq_pkg::row_ctl_t ctl,
  output tlrq_pkg::row_stat_t     stat
);
  import tlrq_pkg::*;

  entry_t                 e_w   [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] v_w;
  logic [QUEUE_DEPTH-1:0] hit_w;
  logic [QUEUE_DEPTH:0]   hole_w;

  assign hole_w[0] = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic   prev_v;
    logic   next_v;
    entry_t next_e;

    if (i == 0) begin : g_first
      assign prev_v = 1'b1;
    end else begin : g_mid
      assign prev_v = v_w[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next_v = 1'b0;
      assign next_e = '0;
    end else begin : g_inner
      assign next_v = v_w[i+1];
      assign next_e = e_w[i+1];
    end

    tlrq_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .prev_v   (prev_v),
      .hole_in  (hole_w[i]),
      .next_v   (next_v),
      .next_e   (next_e),
      .e        (e_w[i]),
      .v        (v_w[i]),
      .hole_out (hole_w[i+1]),
      .hit      (hit_w[i])
    );
  end

  assign stat.head   = e_w[0];
  assign stat.head_v = v_w[0];
  // Outside a removal the slots are packed, so any free slot means room at the tail.
  assign stat.full   = !hole_w[QUEUE_DEPTH];
  assign stat.hit    = |hit_w;

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.cmd == CMD_CLEAR) |=> !stat.head_v)
    else $error("queue row not empty after clear");

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.cmd == CMD_PUSH && !stat.full) |=> stat.head_v)
    else $error("push into a row with room left it empty");

  a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.cmd == CMD_POP && !v_w[1]) |=> !stat.head_v)
    else $error("pop of the only entry left the row occupied");

endmodule

`default_nettype wire

[src/three_level_ready_queue.sv]
// Three-level ready queue: system, interactive and background FIFOs.
//
// Requests arrive on in_req (valid/ready) and carry an operation: push, pop
// from a level, remove by id, or clear all. Every request gives exactly one
// result on out_res (valid/ready), which carries the popped entry, a status
// code, the level used by a push or pop and each queue's emptiness afterwards.
// Each queue is a chain of QUEUE_DEPTH slots; entries slide toward the head.
// Push, pop and clear finish in the cycle they are accepted; the result is
// then registered from the finish state. Remove by id drops matching slots
// in the accept cycle and then compacts the chains in the compact state,
// one hole per cycle, before the finish state registers its result.
// The block handles one request at a time; in_req.ready is high while the
// sequencer is idle, also while an earlier result still waits on out_res.
// If the receiver stalls, the finished result is held until the output
// register frees, and no new request is taken meanwhile.
// Reset (rst_n low, synchronous) empties all three queues and drops any
// pending result; no clearing pass is needed.
`default_nettype none

module three_level_ready_queue (
  input  wire logic clk,
  input  wire logic rst_n,
  tlrq_in_if.sink   in_req,
  tlrq_out_if.source out_res
);
  import tlrq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_COMPACT,
    S_FINISH
  } state_t;

  state_t     state_r;
  logic [CNT_W-1:0] cnt_r;

  row_ctl_t   ctl_w  [LVL_COUNT];
  row_stat_t  stat_w [LVL_COUNT];

  // Fields settled at acceptance, waiting for the queue flags.
  logic [15:0]       p_id_r;
  logic [KIND_W-1:0] p_kind_r;
  logic [PRIO_W-1:0] p_prio_r;
  logic              p_found_r;
  status_t           p_status_r;
  logic [1:0]        p_level_r;

  logic [15:0]       p_id_nxt;
  logic [KIND_W-1:0] p_kind_nxt;
  logic [PRIO_W-1:0] p_prio_nxt;
  logic              p_found_nxt;
  status_t           p_status_nxt;
  logic [1:0]        p_level_nxt;

  logic [15:0]       o_id_r;
  logic [KIND_W-1:0] o_kind_r;
  logic [PRIO_W-1:0] o_prio_r;
  logic              o_found_r;
  status_t           o_status_r;
  logic [1:0]        o_level_r;
  logic              o_sys_e_r;
  logic              o_inter_e_r;
  logic              o_back_e_r;
  logic              o_any_r;
  logic              o_valid_r;

  logic       accept;
  op_t        op;
  entry_t     req_e;
  logic [1:0] push_lvl;
  logic       any_hit;
  logic       out_free;

  assign op       = op_t'(in_req.operation);
  assign accept   = in_req.valid && in_req.ready;
  assign out_free = !o_valid_r || out_res.ready;

  assign req_e.id   = id_of(in_req.proc_id);
  assign req_e.kind = in_req.proc_kind;
  assign req_e.prio = in_req.prio;

  assign push_lvl = (in_req.prio <= 4'd1) ? LVL_SYS :
                    (in_req.prio == 4'd2) ? LVL_INTER : LVL_BACK;
  assign any_hit  = stat_w[0].hit || stat_w[1].hit || stat_w[2].hit;

  assign in_req.ready = (state_r == S_IDLE);

  always_comb begin
    for (int k = 0; k < LVL_COUNT; k++) begin
      ctl_w[k].cmd  = CMD_HOLD;
      ctl_w[k].data = req_e;
      ctl_w[k].key  = req_e.id;
    end
    if (state_r == S_COMPACT) begin
      for (int k = 0; k < LVL_COUNT; k++) begin
        ctl_w[k].cmd = CMD_COMPACT;
      end
    end else if (accept) begin
      case (op)
        OP_PUSH: begin
          for (int k = 0; k < LVL_COUNT; k++) begin
            if (push_lvl == 2'(k) && !stat_w[k].full) begin
              ctl_w[k].cmd = CMD_PUSH;
            end
          end
        end
        OP_POP: begin
          for (int k = 0; k < LVL_COUNT; k++) begin
            if (in_req.level == 2'(k) && stat_w[k].head_v) begin
              ctl_w[k].cmd = CMD_POP;
            end
          end
        end
        OP_REMOVE: begin
          for (int k = 0; k < LVL_COUNT; k++) begin
            ctl_w[k].cmd = CMD_MARK;
          end
        end
        OP_CLEAR: begin
          for (int k = 0; k < LVL_COUNT; k++) begin
            ctl_w[k].cmd = CMD_CLEAR;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    p_id_nxt     = '0;
    p_kind_nxt   = '0;
    p_prio_nxt   = '0;
    p_found_nxt  = 1'b0;
    p_status_nxt = ST_OK;
    p_level_nxt  = LVL_SYS;
    case (op)
      OP_PUSH: begin
        p_level_nxt = push_lvl;
        if ((push_lvl == LVL_SYS && stat_w[0].full) ||
            (push_lvl == LVL_INTER && stat_w[1].full) ||
            (push_lvl == LVL_BACK && stat_w[2].full)) begin
          p_status_nxt = ST_FULL;
        end
      end
      OP_POP: begin
        p_level_nxt  = in_req.level;
        p_status_nxt = ST_EMPTY;
        for (int k = 0; k < LVL_COUNT; k++) begin
          if (in_req.level == 2'(k) && stat_w[k].head_v) begin
            p_status_nxt = ST_OK;
            p_id_nxt     = 16'(stat_w[k].head.id);
            p_kind_nxt   = stat_w[k].head.kind;
            p_prio_nxt   = stat_w[k].head.prio;
          end
        end
      end
      OP_REMOVE: begin
        p_found_nxt  = any_hit;
        p_status_nxt = any_hit ? ST_OK : ST_NOTFOUND;
      end
      OP_CLEAR: begin
      end
      default: begin
      end
    endcase
  end

  for (genvar k = 0; k < LVL_COUNT; k++) begin : g_row
    tlrq_row u_row (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl_w[k]),
      .stat  (stat_w[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      o_valid_r <= 1'b0;
    end else begin
      // In the finish state the output register is reloaded instead.
      if (o_valid_r && out_res.ready && state_r != S_FINISH) begin
        o_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            p_id_r     <= p_id_nxt;
            p_kind_r   <= p_kind_nxt;
            p_prio_r   <= p_prio_nxt;
            p_found_r  <= p_found_nxt;
            p_status_r <= p_status_nxt;
            p_level_r  <= p_level_nxt;
            cnt_r      <= '0;
            state_r    <= (op == OP_REMOVE) ? S_COMPACT : S_FINISH;
          end
        end
        S_COMPACT: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(QUEUE_DEPTH - 1)) begin
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            o_valid_r   <= 1'b1;
            o_id_r      <= p_id_r;
            o_kind_r    <= p_kind_r;
            o_prio_r    <= p_prio_r;
            o_found_r   <= p_found_r;
            o_status_r  <= p_status_r;
            o_level_r   <= p_level_r;
            o_sys_e_r   <= !stat_w[0].head_v;
            o_inter_e_r <= !stat_w[1].head_v;
            o_back_e_r  <= !stat_w[2].head_v;
            o_any_r     <= stat_w[0].head_v || stat_w[1].head_v || stat_w[2].head_v;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_res.valid       = o_valid_r;
  assign out_res.out_id      = o_id_r;
  assign out_res.out_kind    = o_kind_r;
  assign out_res.out_prio    = o_prio_r;
  assign out_res.found       = o_found_r;
  assign out_res.status      = o_status_r;
  assign out_res.level_used  = o_level_r;
  assign out_res.sys_empty   = o_sys_e_r;
  assign out_res.inter_empty = o_inter_e_r;
  assign out_res.back_empty  = o_back_e_r;
  assign out_res.any_ready   = o_any_r;

  a_remove_compacts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && op == OP_REMOVE) |=> (state_r == S_COMPACT))
    else $error("remove request did not start compaction");

  a_short_op_finishes: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && op != OP_REMOVE) |=> (state_r == S_FINISH))
    else $error("short request did not go straight to finish");

  a_any_ready_flags: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid_r |-> (o_any_r == !(o_sys_e_r && o_inter_e_r && o_back_e_r)))
    else $error("any_ready disagrees with the per-queue empty flags");

  a_empty_pop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (o_valid_r && o_status_r != ST_OK) |-> (o_id_r == 16'd0))
    else $error("failed request returned a nonzero id");

endmodule

`default_nettype wire
